[src/uktsd_pkg.sv]
// ----------------------------------------------------------------------------
// uktsd_pkg: shared types and constants for the key-value table
// Entry layout, operation and status codes, default table depth.
// ----------------------------------------------------------------------------
package uktsd_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 128;
  localparam int unsigned KEY_W   = 232;
  localparam int unsigned VALUE_W = 112;
  localparam int unsigned IDX_W   = 7;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_READ_ALT = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_READ_OK   = 3'd5,
    ST_BEYOND    = 3'd6
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } entry_t;

endpackage

[src/uktsd_cell.sv]
// ----------------------------------------------------------------------------
// uktsd_cell: one slot of the table ring
// Holds one entry and passes it to the next cell when the ring rotates.
// ----------------------------------------------------------------------------
module uktsd_cell (
  input  logic              clk,
  input  logic              shift,
  input  uktsd_pkg::entry_t din,
  output uktsd_pkg::entry_t dout
);

  uktsd_pkg::entry_t entry;

  // take the neighbor's entry on rotate
  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= din;
    end
  end

  assign dout = entry;

endmodule

[src/uktsd_ctrl.sv]
// ----------------------------------------------------------------------------
// uktsd_ctrl: sequencer for the table ring
// Rotates the ring one slot a cycle during a pass, compares the head entry and rewrites it.
// ----------------------------------------------------------------------------
module uktsd_ctrl #(
  parameter int unsigned TABLE_ENTRIES = uktsd_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             op,
  input  uktsd_pkg::entry_t      in_entry,
  input  logic [uktsd_pkg::IDX_W-1:0] in_idx,
  input  uktsd_pkg::entry_t      head,
  output logic                   shift,
  output uktsd_pkg::entry_t      tail_in,
  output logic                   res_valid,
  input  logic                   res_ready,
  output logic [2:0]             res_status,
  output logic [7:0]             res_count,
  output uktsd_pkg::entry_t      res_entry
);

  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  // rotation position counts slots visited; ring length is TABLE_ENTRIES
  localparam int unsigned POS_W = $clog2(TABLE_ENTRIES + 1);
  // common width for comparing the read index against position and count
  localparam int unsigned CMP_W = (POS_W > uktsd_pkg::IDX_W) ? POS_W : uktsd_pkg::IDX_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_FIX   = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [POS_W-1:0]  pos;
  logic [1:0]        cur_op;
  uktsd_pkg::entry_t cur;
  logic [uktsd_pkg::IDX_W-1:0] cur_idx;
  logic              found;
  logic [POS_W-1:0]  match_pos;
  uktsd_pkg::entry_t last_entry;
  logic              pass2;

  logic [POS_W-1:0]  cnt_ext;
  logic              at_live;
  logic              key_eq;

  assign cnt_ext  = POS_W'(count);
  assign at_live  = pos < cnt_ext;
  assign key_eq   = head.key == cur.key;
  assign in_ready = (state == S_IDLE) && !res_valid;

  // ring rotates every cycle of a pass; write back the head, possibly replaced
  always_comb begin
    shift   = (state == S_SCAN) || (state == S_FIX);
    tail_in = head;
    if (state == S_FIX) begin
      if (cur_op == uktsd_pkg::OP_ADD && pos == cnt_ext) begin
        tail_in = cur;
      end else if (cur_op == uktsd_pkg::OP_REMOVE && pos == match_pos) begin
        tail_in = last_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
      pos       <= '0;
      found     <= 1'b0;
      pass2     <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cur     <= in_entry;
            cur_op  <= op;
            cur_idx <= in_idx;
            pos     <= '0;
            found   <= 1'b0;
            state   <= S_SCAN;
          end
        end
        // first pass: search key, capture the read slot and the last entry
        S_SCAN: begin
          if (at_live && key_eq && !found) begin
            found     <= 1'b1;
            match_pos <= pos;
          end
          if (count != '0 && pos == cnt_ext - POS_W'(1)) begin
            last_entry <= head;
          end
          if (CMP_W'(pos) == CMP_W'(cur_idx) && at_live) begin
            res_entry <= head;
          end
          if (pos == POS_W'(TABLE_ENTRIES - 1)) begin
            pos   <= '0;
            state <= S_OUT;
          end else begin
            pos <= pos + POS_W'(1);
          end
        end
        // second pass: apply the append or the swap
        S_FIX: begin
          if (pos == POS_W'(TABLE_ENTRIES - 1)) begin
            pos   <= '0;
            state <= S_OUT;
          end else begin
            pos <= pos + POS_W'(1);
          end
        end
        S_OUT: begin
          if (!pass2 && cur_op == uktsd_pkg::OP_ADD && !found
              && cnt_ext < POS_W'(TABLE_ENTRIES)) begin
            pass2 <= 1'b1;
            state <= S_FIX;
          end else if (!pass2 && cur_op == uktsd_pkg::OP_REMOVE && found) begin
            pass2 <= 1'b1;
            state <= S_FIX;
          end else begin
            pass2     <= 1'b0;
            res_valid <= 1'b1;
            state     <= S_IDLE;
            priority if (cur_op == uktsd_pkg::OP_ADD) begin
              if (found) begin
                res_status <= uktsd_pkg::ST_DUPLICATE;
              end else if (!pass2) begin
                res_status <= uktsd_pkg::ST_FULL;
              end else begin
                res_status <= uktsd_pkg::ST_ADDED;
                count      <= count + CNT_W'(1);
              end
              res_count <= 8'(pass2 ? count + CNT_W'(1) : count);
              res_entry <= '0;
            end else if (cur_op == uktsd_pkg::OP_REMOVE) begin
              res_status <= found ? uktsd_pkg::ST_REMOVED : uktsd_pkg::ST_NOT_FOUND;
              if (found) begin
                count <= count - CNT_W'(1);
              end
              res_count <= 8'(found ? count - CNT_W'(1) : count);
              res_entry <= '0;
            end else begin
              res_count <= 8'(count);
              if (CMP_W'(cur_idx) < CMP_W'(count)) begin
                res_status <= uktsd_pkg::ST_READ_OK;
              end else begin
                res_status <= uktsd_pkg::ST_BEYOND;
                res_entry  <= '0;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/unique_key_table_swap_delete.sv]
// ----------------------------------------------------------------------------
// unique_key_table_swap_delete: packed key-value table with swap delete
// Ring of entry cells rotated by a sequencer that searches and rewrites.
// ----------------------------------------------------------------------------
// The table is a ring of TABLE_ENTRIES cells that rotates one slot a cycle while a pass runs.
// Every transaction makes one full rotation to search the key and pick up the
// read slot and the last live entry. An add that appends and a remove that
// hits make a second rotation that writes the entry back in place. One
// transaction is in flight at a time; the result register holds until taken.
module unique_key_table_swap_delete #(
  parameter int unsigned TABLE_ENTRIES = uktsd_pkg::TABLE_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // opcode[1:0], key_word0..3[233:2], value_word0..1[345:234], entry_index[352:346]
  input  logic [359:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[2:0], live_count[10:3], out_key_word0..3[242:11], out_value[354:243]
  output logic [359:0] m_tdata
);

  uktsd_pkg::entry_t ring [TABLE_ENTRIES];
  uktsd_pkg::entry_t tail_in;
  uktsd_pkg::entry_t in_entry;
  uktsd_pkg::entry_t res_entry;
  logic              shift;
  logic [2:0]        res_status;
  logic [7:0]        res_count;

  assign in_entry.key   = s_tdata[233:2];
  assign in_entry.value = s_tdata[345:234];

  // ring: cell i feeds cell i-1, head is cell 0, tail is the last cell
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    uktsd_cell u_cell (
      .clk  (clk),
      .shift(shift),
      .din  ((i == TABLE_ENTRIES - 1) ? tail_in : ring[(i + 1) % TABLE_ENTRIES]),
      .dout (ring[i])
    );
  end

  uktsd_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .op        (s_tdata[1:0]),
    .in_entry  (in_entry),
    .in_idx    (s_tdata[352:346]),
    .head      (ring[0]),
    .shift     (shift),
    .tail_in   (tail_in),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res_status(res_status),
    .res_count (res_count),
    .res_entry (res_entry)
  );

  assign m_tdata = {5'd0, res_entry.value, res_entry.key, res_count, res_status};

endmodule

[src/uktsd_checker.sv]
// ----------------------------------------------------------------------------
// uktsd_checker: port-level checks for the key-value table
// Handshake and result sanity seen from the ports.
// ----------------------------------------------------------------------------
module uktsd_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [359:0] m_tdata
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // no new input while a result waits
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input ready while result pending");

  // a result follows an accepted transaction, never in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !m_tvalid)
    else $error("result too early");

  // status code in range
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] != 3'd7)
    else $error("bad status");

endmodule

bind unique_key_table_swap_delete uktsd_checker u_uktsd_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
